### hw/rtl/mfhp_pkg.sv
// Shared types and constants for the MAC frame header parser.
// Holds the element and result payload structs and the header layout struct.
// No dependencies.
`default_nettype none

package mfhp_pkg;

    // Input element as it travels on the element channel
    typedef struct packed {
        logic [7:0] element_value;
        logic       first_element;
    } elem_t;

    // One parsed frame header
    typedef struct packed {
        logic        header_ok;
        logic        addressing_parsed;
        logic [15:0] frame_control;
        logic [7:0]  seq_number;
        logic [15:0] dest_pan;
        logic [63:0] dest_address;
        logic [15:0] src_pan;
        logic [63:0] src_address;
        logic [4:0]  payload_index;
        logic [7:0]  crc_value;
        logic [7:0]  rssi_value;
        logic [7:0]  frame_length;
    } result_t;

    // Byte positions of the header fields, derived from frame control
    typedef struct packed {
        logic       dest;       // destination PAN and address present
        logic [3:0] dest_len;   // destination address bytes
        logic       src_pan;    // source PAN present
        logic [4:0] src_pan_pos;
        logic       src_addr;   // source address present
        logic [4:0] src_addr_pos;
        logic [3:0] src_len;    // source address bytes
        logic [4:0] payload_pos;
        logic       bad;        // intra-PAN with a zero address mode
    } layout_t;

    // Frame control bit positions
    localparam int INTRA_PAN_BIT = 6;
    localparam int DEST_MODE_LSB = 10;
    localparam int SRC_MODE_LSB  = 14;

    // Address modes
    localparam logic [1:0] MODE_NONE  = 2'd0;
    localparam logic [1:0] MODE_SHORT = 2'd2;

    localparam logic [3:0] SHORT_ADDR_BYTES = 4'd2;
    localparam logic [3:0] EXT_ADDR_BYTES   = 4'd8;
    localparam logic [4:0] PAN_BYTES        = 5'd2;

    // Element positions within a frame
    localparam logic [7:0] POS_FC_LO     = 8'd1;
    localparam logic [7:0] POS_FC_HI     = 8'd2;
    localparam logic [7:0] POS_SEQ       = 8'd3;
    localparam logic [7:0] POS_DEST_ADDR = 8'd6;
    localparam logic [4:0] POS_NO_DEST   = 5'd4;
    localparam logic [4:0] POS_AFTER_DPAN = 5'd6;

    // Frames no longer than this carry no addressing
    localparam logic [7:0] MIN_ADDR_LEN = 8'd5;

endpackage

`default_nettype wire

### hw/rtl/mfhp_layout.sv
// Header layout decoder: field presence and byte positions from frame control.
// Depends on mfhp_pkg.
`default_nettype none

module mfhp_layout
(
    input  wire logic [15:0]      frame_control,
    output mfhp_pkg::layout_t     layout
);

    logic [1:0] dest_mode;
    logic [1:0] src_mode;
    logic       intra;
    logic [4:0] hdr_end;

    assign dest_mode = frame_control[mfhp_pkg::DEST_MODE_LSB +: 2];
    assign src_mode  = frame_control[mfhp_pkg::SRC_MODE_LSB +: 2];
    assign intra     = frame_control[mfhp_pkg::INTRA_PAN_BIT];

    always_comb
    begin
        layout.bad      = intra && (dest_mode == mfhp_pkg::MODE_NONE
                                    || src_mode == mfhp_pkg::MODE_NONE);
        layout.dest     = intra || (dest_mode != mfhp_pkg::MODE_NONE);
        layout.dest_len = (dest_mode == mfhp_pkg::MODE_SHORT) ?
                          mfhp_pkg::SHORT_ADDR_BYTES : mfhp_pkg::EXT_ADDR_BYTES;
        layout.src_pan  = !intra && (src_mode != mfhp_pkg::MODE_NONE);
        layout.src_addr = (src_mode != mfhp_pkg::MODE_NONE);
        layout.src_len  = (src_mode == mfhp_pkg::MODE_SHORT) ?
                          mfhp_pkg::SHORT_ADDR_BYTES : mfhp_pkg::EXT_ADDR_BYTES;

        hdr_end = layout.dest ?
                  (mfhp_pkg::POS_AFTER_DPAN + {1'b0, layout.dest_len}) :
                  mfhp_pkg::POS_NO_DEST;
        layout.src_pan_pos  = hdr_end;
        layout.src_addr_pos = hdr_end + (layout.src_pan ? mfhp_pkg::PAN_BYTES : 5'd0);
        layout.payload_pos  = layout.src_addr_pos +
                              (layout.src_addr ? {1'b0, layout.src_len} : 5'd0);
    end

endmodule

`default_nettype wire

### hw/rtl/mac_frame_header_parser.sv
// result_valid rises at the edge that accepts element N, so the
// result can be taken at the next edge at the earliest.
// Throughput: one element per cycle; elem_ready drops only while a result waits
// in the output register and result_ready is low.
// Reset (rst_n low, asynchronous): drop any frame in progress and clear result_valid.
// Top level of the MAC frame header parser; depends on mfhp_pkg and mfhp_layout.
`default_nettype none

module mac_frame_header_parser
(
    input  wire logic              clk,
    input  wire logic              rst_n,

    // element channel
    input  wire logic              elem_valid,
    output logic                   elem_ready,
    input  wire mfhp_pkg::elem_t   elem,

    // result channel
    output logic                   result_valid,
    input  wire logic              result_ready,
    output mfhp_pkg::result_t      result
);

    // Frame tracking (control state)
    logic        in_frame_reg, in_frame_next;
    logic [7:0]  position_reg, position_next;
    logic [7:0]  length_reg, length_next;

    // Captured header fields; each length element clears them and loads RSSI with the length
    logic [15:0] control_reg, control_next;
    logic [7:0]  sequence_reg, sequence_next;
    logic [15:0] dest_pan_reg, dest_pan_next;
    logic [63:0] dest_addr_reg, dest_addr_next;
    logic [15:0] src_pan_reg, src_pan_next;
    logic [63:0] src_addr_reg, src_addr_next;
    logic [7:0]  rssi_reg, rssi_next;

    // Output register
    logic                 result_valid_reg, result_valid_next;
    mfhp_pkg::result_t    result_reg, result_next;

    logic                 accept;
    logic                 emit;
    logic [7:0]           pos;
    logic [7:0]           v;
    logic [7:0]           da_off;
    logic [7:0]           sp_pos;
    logic [7:0]           sa_pos;
    logic [7:0]           sa_off;
    logic                 parse;
    logic                 ok;
    logic                 addr;
    mfhp_pkg::layout_t    layout;

    // Layout only matters from element 4 on, when frame control is complete
    mfhp_layout u_layout
    (
        .frame_control (control_reg),
        .layout        (layout)
    );

    // Take a new element whenever the output register is free or being drained
    assign elem_ready = !result_valid_reg || result_ready;
    assign accept     = elem_valid && elem_ready;
    assign v          = elem.element_value;
    assign pos        = position_reg + 8'd1;

    assign sp_pos = {3'b000, layout.src_pan_pos};
    assign sa_pos = {3'b000, layout.src_addr_pos};
    assign da_off = pos - mfhp_pkg::POS_DEST_ADDR;
    assign sa_off = pos - sa_pos;

    always_comb
    begin
        in_frame_next  = in_frame_reg;
        position_next  = position_reg;
        length_next    = length_reg;
        control_next   = control_reg;
        sequence_next  = sequence_reg;
        dest_pan_next  = dest_pan_reg;
        dest_addr_next = dest_addr_reg;
        src_pan_next   = src_pan_reg;
        src_addr_next  = src_addr_reg;
        rssi_next      = rssi_reg;
        emit           = 1'b0;

        if (accept && elem.first_element)
        begin
            // Length element: start over, abandoning any frame in progress
            in_frame_next  = (v != 8'd0);
            position_next  = 8'd0;
            length_next    = v;
            control_next   = 16'd0;
            sequence_next  = 8'd0;
            dest_pan_next  = 16'd0;
            dest_addr_next = 64'd0;
            src_pan_next   = 16'd0;
            src_addr_next  = 64'd0;
            rssi_next      = v;
        end
        else if (accept && in_frame_reg)
        begin
            position_next = pos;

            if (pos == mfhp_pkg::POS_FC_LO)
            begin
                control_next[7:0] = v;
            end
            else if (pos == mfhp_pkg::POS_FC_HI)
            begin
                control_next[15:8] = v;
            end
            else if (pos == mfhp_pkg::POS_SEQ)
            begin
                sequence_next = v;
            end
            else
            begin
                // Each byte lane is written once per frame, so a plain store does
                if (layout.dest && pos < mfhp_pkg::POS_DEST_ADDR)
                begin
                    dest_pan_next[{pos[0], 3'b000} +: 8] = v;
                end
                if (layout.dest && pos >= mfhp_pkg::POS_DEST_ADDR
                    && pos < mfhp_pkg::POS_DEST_ADDR + {4'd0, layout.dest_len})
                begin
                    dest_addr_next[{da_off[2:0], 3'b000} +: 8] = v;
                end
                if (layout.src_pan && pos >= sp_pos && pos < sp_pos + 8'd2)
                begin
                    src_pan_next[{(pos[0] ^ sp_pos[0]), 3'b000} +: 8] = v;
                end
                if (layout.src_addr && pos >= sa_pos
                    && pos < sa_pos + {4'd0, layout.src_len})
                begin
                    src_addr_next[{sa_off[2:0], 3'b000} +: 8] = v;
                end
            end

            // Next to last element carries the signal strength
            if (length_reg >= 8'd2 && pos == length_reg - 8'd1)
            begin
                rssi_next = v;
            end

            if (pos == length_reg)
            begin
                emit          = 1'b1;
                in_frame_next = 1'b0;
            end
        end
    end

    // Result assembly; parse implies element 6 or later, so control_reg is final
    always_comb
    begin
        parse = (length_reg > mfhp_pkg::MIN_ADDR_LEN);
        ok    = !(parse && layout.bad);
        addr  = parse && ok;

        result_next.header_ok         = ok;
        result_next.addressing_parsed = addr;
        result_next.frame_control     = control_next;
        result_next.seq_number        = sequence_next;
        result_next.dest_pan          = addr ? dest_pan_next : 16'd0;
        result_next.dest_address      = addr ? dest_addr_next : 64'd0;
        result_next.src_pan           = addr ? src_pan_next : 16'd0;
        result_next.src_address       = addr ? src_addr_next : 64'd0;
        result_next.payload_index     = addr ? layout.payload_pos : mfhp_pkg::POS_NO_DEST;
        result_next.crc_value         = v;
        result_next.rssi_value        = rssi_next;
        result_next.frame_length      = length_reg;
    end

    // Hold a result until taken; load a new one on the last element of a frame
    always_comb
    begin
        if (emit)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
        else
        begin
            result_valid_next = result_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg     <= 1'b0;
            position_reg     <= 8'd0;
            length_reg       <= 8'd0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            in_frame_reg     <= in_frame_next;
            position_reg     <= position_next;
            length_reg       <= length_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Field capture: every field is rewritten by the length element before use
    always_ff @(posedge clk)
    begin
        control_reg   <= control_next;
        sequence_reg  <= sequence_next;
        dest_pan_reg  <= dest_pan_next;
        dest_addr_reg <= dest_addr_next;
        src_pan_reg   <= src_pan_next;
        src_addr_reg  <= src_addr_next;
        rssi_reg      <= rssi_next;
        if (emit)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Position never runs past the frame length while a frame is open
    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        in_frame_reg |-> (position_reg < length_reg))
        else $error("frame position passed frame length");

    // A new result appears only after an accepted element
    a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(elem_valid && elem_ready))
        else $error("result appeared without an accepted element");

    // A rejected header only comes from a frame long enough to carry addressing
    a_bad_hdr_len: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.header_ok) |->
            (result.frame_length > mfhp_pkg::MIN_ADDR_LEN && !result.addressing_parsed))
        else $error("header_ok low on a short frame");

    // Without addressing, payload starts right after the sequence number
    a_no_addr_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.addressing_parsed) |->
            (result.payload_index == mfhp_pkg::POS_NO_DEST && result.dest_pan == 16'd0
             && result.src_address == 64'd0))
        else $error("address fields set without addressing");

endmodule

`default_nettype wire

### verif/mfhp_header_checker.sv
// Scoreboard for the MAC frame header parser: watches both channels, predicts each header.
// Compares every result transaction with the oldest predicted header, field by field.
// Depends on mfhp_pkg.
`timescale 1ns / 100ps

module mfhp_header_checker
    import mfhp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    elem_valid,
    input  logic    elem_ready,
    input  elem_t   elem,
    input  logic    result_valid,
    input  logic    result_ready,
    input  result_t result,
    output int      mismatches,
    output int      expected_left
);

    localparam int DPAN_POS = int'(POS_SEQ) + 1;

    // Predictor state
    logic [7:0]  pos_cnt    = '0;
    logic        frame_open = 1'b0;
    logic [7:0]  frame_len  = '0;
    logic [15:0] fc_reg     = '0;
    logic [7:0]  seq_reg    = '0;
    logic [15:0] dpan_reg   = '0;
    logic [63:0] daddr_reg  = '0;
    logic [15:0] span_reg   = '0;
    logic [63:0] saddr_reg  = '0;
    logic [7:0]  rssi_reg   = '0;

    result_t     header_q[$];
    result_t     hdr_pred;
    result_t     hdr_exp;
    bit          hdr_done;

    initial
    begin
        mismatches    = 0;
        expected_left = 0;
    end

    function automatic layout_t header_layout(input logic [15:0] fc);
        layout_t    lay;
        logic [1:0] dm;
        logic [1:0] sm;
        logic       intra;
        logic [4:0] after_dest;
        dm    = fc[DEST_MODE_LSB +: 2];
        sm    = fc[SRC_MODE_LSB +: 2];
        intra = fc[INTRA_PAN_BIT];
        lay.bad      = intra && (dm == MODE_NONE || sm == MODE_NONE);
        lay.dest     = intra || (dm != MODE_NONE);
        lay.dest_len = (dm == MODE_SHORT) ? SHORT_ADDR_BYTES : EXT_ADDR_BYTES;
        lay.src_pan  = !intra && (sm != MODE_NONE);
        lay.src_addr = (sm != MODE_NONE);
        lay.src_len  = (sm == MODE_SHORT) ? SHORT_ADDR_BYTES : EXT_ADDR_BYTES;
        after_dest   = lay.dest ? POS_AFTER_DPAN + 5'(lay.dest_len) : POS_NO_DEST;
        lay.src_pan_pos  = after_dest;
        lay.src_addr_pos = after_dest + (lay.src_pan ? PAN_BYTES : 5'd0);
        lay.payload_pos  = lay.src_addr_pos + (lay.src_addr ? 5'(lay.src_len) : 5'd0);
        return lay;
    endfunction

    task automatic clear_header();
        pos_cnt   = '0;
        frame_len = '0;
        fc_reg    = '0;
        seq_reg   = '0;
        dpan_reg  = '0;
        daddr_reg = '0;
        span_reg  = '0;
        saddr_reg = '0;
        rssi_reg  = '0;
    endtask

    // Advance the parser by one element; raise done when element N closes the frame
    task automatic predict_header(input elem_t e, output bit done, output result_t hdr);
        int         p;
        int         sph;
        int         sah;
        layout_t    lay;
        logic [7:0] v;
        logic       parse;
        logic       ok;
        logic       addr_ok;
        done = 1'b0;
        hdr  = '0;
        v    = e.element_value;
        if (e.first_element)
        begin
            clear_header();
            frame_len  = v;
            rssi_reg   = v;
            frame_open = (v != 8'd0);
            return;
        end
        if (!frame_open)
            return;

        pos_cnt = pos_cnt + 8'd1;
        p = int'(pos_cnt);
        if (p == int'(POS_FC_LO))
            fc_reg[7:0] = v;
        else if (p == int'(POS_FC_HI))
            fc_reg[15:8] = v;
        else if (p == int'(POS_SEQ))
            seq_reg = v;
        else
        begin
            lay = header_layout(fc_reg);
            sph = int'(lay.src_pan_pos);
            sah = int'(lay.src_addr_pos);
            if (lay.dest && p < int'(POS_DEST_ADDR))
                dpan_reg[(p - DPAN_POS) * 8 +: 8] = v;
            if (lay.dest && p >= int'(POS_DEST_ADDR)
                    && p < int'(POS_DEST_ADDR) + int'(lay.dest_len))
                daddr_reg[(p - int'(POS_DEST_ADDR)) * 8 +: 8] = v;
            if (lay.src_pan && p >= sph && p < sph + int'(PAN_BYTES))
                span_reg[(p - sph) * 8 +: 8] = v;
            if (lay.src_addr && p >= sah && p < sah + int'(lay.src_len))
                saddr_reg[(p - sah) * 8 +: 8] = v;
        end

        if (frame_len >= 8'd2 && p == int'(frame_len) - 1)
            rssi_reg = v;

        if (p == int'(frame_len))
        begin
            lay     = header_layout(fc_reg);
            parse   = (frame_len > MIN_ADDR_LEN);
            ok      = !(parse && lay.bad);
            addr_ok = parse && ok;
            hdr.header_ok         = ok;
            hdr.addressing_parsed = addr_ok;
            hdr.frame_control     = fc_reg;
            hdr.seq_number        = seq_reg;
            hdr.dest_pan          = addr_ok ? dpan_reg  : 16'd0;
            hdr.dest_address      = addr_ok ? daddr_reg : 64'd0;
            hdr.src_pan           = addr_ok ? span_reg  : 16'd0;
            hdr.src_address       = addr_ok ? saddr_reg : 64'd0;
            hdr.payload_index     = addr_ok ? lay.payload_pos : POS_NO_DEST;
            hdr.crc_value         = v;
            hdr.rssi_value        = rssi_reg;
            hdr.frame_length      = frame_len;
            frame_open = 1'b0;
            done       = 1'b1;
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            clear_header();
            frame_open = 1'b0;
            header_q.delete();
        end
        else
        begin
            // Retire the result transaction first: it is always older than this edge's element
            if (result_valid && result_ready)
            begin
                if (header_q.size() == 0)
                begin
                    $error("result transaction with no header pending");
                    mismatches++;
                end
                else
                begin
                    hdr_exp = header_q.pop_front();
                    check_field("header_ok", hdr_exp.header_ok, result.header_ok);
                    check_field("addressing_parsed", hdr_exp.addressing_parsed,
                                result.addressing_parsed);
                    check_field("frame_control", hdr_exp.frame_control, result.frame_control);
                    check_field("seq_number", hdr_exp.seq_number, result.seq_number);
                    check_field("dest_pan", hdr_exp.dest_pan, result.dest_pan);
                    check_field("dest_address", hdr_exp.dest_address, result.dest_address);
                    check_field("src_pan", hdr_exp.src_pan, result.src_pan);
                    check_field("src_address", hdr_exp.src_address, result.src_address);
                    check_field("payload_index", hdr_exp.payload_index, result.payload_index);
                    check_field("crc_value", hdr_exp.crc_value, result.crc_value);
                    check_field("rssi_value", hdr_exp.rssi_value, result.rssi_value);
                    check_field("frame_length", hdr_exp.frame_length, result.frame_length);
                end
            end
            if (elem_valid && elem_ready)
            begin
                predict_header(elem, hdr_done, hdr_pred);
                if (hdr_done)
                    header_q.push_back(hdr_pred);
            end
        end
        expected_left <= header_q.size();
    end

endmodule

### verif/tb.sv
// Top of the header parser testbench: clock, reset, element stimulus and result backpressure.
// Instantiates mac_frame_header_parser and mfhp_header_checker; depends on mfhp_pkg.
`timescale 1ns / 100ps

module tb;
    import mfhp_pkg::*;

    // Generous watchdog: the slowest legal run stays far below this
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int TARGET_ELEMS = 1700;
    localparam int HOLD_CYCLES  = 400;

    logic    clk          = 1'b0;
    logic    rst_n        = 1'b0;
    logic    elem_valid   = 1'b0;
    logic    elem_ready;
    elem_t   elem         = '0;
    logic    result_valid;
    logic    result_ready = 1'b0;
    result_t result;

    int      mismatches;
    int      expected_left;
    int      elems_sent  = 0;
    int      burst_left  = 0;
    int      cycle_count = 0;

    always #10 clk = ~clk;

    mac_frame_header_parser dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .elem_valid   (elem_valid),
        .elem_ready   (elem_ready),
        .elem         (elem),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    mfhp_header_checker u_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .elem_valid    (elem_valid),
        .elem_ready    (elem_ready),
        .elem          (elem),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .result        (result),
        .mismatches    (mismatches),
        .expected_left (expected_left)
    );

    // Offer one element and hold it until the transaction completes.
    // Insert a random idle gap first; bursts suppress gaps for a stretch.
    task automatic send_elem(input logic [7:0] v, input logic f);
        int gap;
        int r;
        gap = 0;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
                gap = 0;
            else if (r < 85)
                gap = $urandom_range(1, 2);
            else if (r < 97)
                gap = $urandom_range(3, 8);
            else if (r < 99)
                gap = $urandom_range(20, 60);
            else
                burst_left = $urandom_range(30, 150);
        end
        if (gap > 0)
        begin
            elem_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        elem_valid <= 1'b1;
        elem       <= '{element_value: v, first_element: f};
        @(posedge clk);
        while (!elem_ready)
            @(posedge clk);
        elems_sent++;
    endtask

    // Send a length element, then the first count frame bytes.
    // Bytes 1 and 2 carry the frame control; the rest are random.
    // A count below len leaves the frame open for the next length to abandon.
    task automatic send_frame(input int len, input logic [15:0] fc, input int count);
        logic [7:0] b;
        send_elem(8'(len), 1'b1);
        for (int i = 1; i <= count; i++)
        begin
            if (i == int'(POS_FC_LO))
                b = fc[7:0];
            else if (i == int'(POS_FC_HI))
                b = fc[15:8];
            else
                b = 8'($urandom);
            send_elem(b, 1'b0);
        end
    endtask

    // Watchdog: end the run if the traffic never drains
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb NOT OK");
        $finish;
    end

    // Result side backpressure: one long hold-off early on so the output register
    // fills and the element channel stalls, then random runs and gaps.
    initial
    begin
        int run;
        int gap;
        int r;
        @(posedge rst_n);
        @(posedge clk);
        result_ready <= 1'b1;
        repeat (40) @(posedge clk);
        result_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        forever
        begin
            result_ready <= 1'b1;
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 300) : $urandom_range(1, 12);
            repeat (run) @(posedge clk);
            r = $urandom_range(0, 9);
            if (r < 6)
                gap = $urandom_range(1, 3);
            else if (r < 9)
                gap = $urandom_range(4, 15);
            else
                gap = $urandom_range(20, 120);
            result_ready <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    end

    // Element stimulus and verdict
    initial
    begin
        int         r;
        int         len;
        logic [15:0] fc;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Stray byte outside any frame: drop it
        send_elem(8'h5A, 1'b0);
        // Zero length starts no frame
        send_elem(8'h00, 1'b1);
        // Length of one: RSSI reads back the length element itself
        send_elem(8'h01, 1'b1);
        send_elem(8'hFF, 1'b0);
        // New length mid-frame abandons the open frame
        send_elem(8'd12, 1'b1);
        send_elem(8'h40, 1'b0);
        send_elem(8'hFF, 1'b0);
        // Short frame of five: no addressing, payload at 4
        send_elem(8'd5, 1'b1);
        send_elem(8'h41, 1'b0);
        send_elem(8'h88, 1'b0);
        send_elem(8'h00, 1'b0);
        send_elem(8'hAA, 1'b0);
        send_elem(8'h55, 1'b0);
        // Intra-PAN with both modes zero: header rejected
        send_elem(8'd7, 1'b1);
        send_elem(8'h40, 1'b0);
        send_elem(8'h00, 1'b0);
        send_elem(8'h12, 1'b0);
        send_elem(8'hFF, 1'b0);
        send_elem(8'h00, 1'b0);
        send_elem(8'hC3, 1'b0);
        send_elem(8'h3C, 1'b0);

        // Longest frame once, then mostly complete frames with random headers
        send_frame(255, 16'($urandom), 255);
        while (elems_sent < TARGET_ELEMS)
        begin
            r   = $urandom_range(0, 99);
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(31, 255) : $urandom_range(1, 30);
            fc  = 16'($urandom);
            if (r < 80)
                send_frame(len, fc, len);
            else if (r < 90)
                send_frame(len, fc, $urandom_range(0, len - 1));
            else
                send_elem(8'($urandom), 1'($urandom_range(0, 1)));
        end
        elem_valid <= 1'b0;

        // Drain: let the checker's count settle, then wait for the last header
        @(posedge clk);
        while (expected_left != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        if (mismatches == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
